// ----- rtl/dwp_pkg.sv -----
// Shared types and constants of the dual wheel PID speed loop.
package dwp_pkg;

  localparam int GAIN_W     = 24;
  localparam int RAMP_W     = 16;
  localparam int CNT_W      = 16;
  localparam int DRV_W      = 17;
  localparam int TGT_W      = 19;
  localparam int ERR_W      = 21;
  localparam int DIFF_W     = 22;
  localparam int SUM_W      = 32;
  localparam int NUM_W      = 60;
  localparam int O_W        = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // pipeline stages inside a lane, ahead of the merge register
  localparam int NSTG = 6;

  // divide by 128000 = 1024 * 125: a shift, then a reciprocal multiply by 2^35/125
  localparam int DIV_SHIFT   = 10;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd274877907;

  localparam logic [TGT_W-1:0]  TGT_BASE       = 19'd70;
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 24'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP     = 3'd0,
    CFG_GAIN_INTEGRAL = 3'd1,
    CFG_GAIN_DERIV    = 3'd2,
    CFG_RAMP_LIMIT    = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic            out_load;
  } stage_ctl_t;

endpackage

// ----- rtl/dwp_if.sv -----
// Channel interfaces: input item, result item and configuration write.
interface dwp_in_if;
  import dwp_pkg::*;
  logic             valid;
  logic             ready;
  logic             run_enable;
  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  modport source (output valid, run_enable, left_count, right_count, input ready);
  modport sink   (input valid, run_enable, left_count, right_count, output ready);
endinterface

interface dwp_out_if;
  import dwp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] left_drive;
  logic signed [DRV_W-1:0] right_drive;
  logic [TGT_W-1:0]        target_tenths;
  modport source (output valid, left_drive, right_drive, target_tenths, input ready);
  modport sink   (input valid, left_drive, right_drive, target_tenths, output ready);
endinterface

interface dwp_cfg_if;
  import dwp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dwp_ctrl.sv -----
// Control: registers, ramp target, stage handshake and side-band pipeline.
module dwp_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_run,
  output logic                            in_ready,
  input  logic                            out_ready,
  output logic                            out_valid,
  input  logic                            cfg_valid,
  input  logic [dwp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cfg_ready,
  output dwp_pkg::stage_ctl_t             ctl,
  output dwp_pkg::gains_t                 gains,
  output logic [dwp_pkg::TGT_W-1:0]       target_now,
  output logic                            run_last,
  output logic [dwp_pkg::TGT_W-1:0]       target_last
);
  import dwp_pkg::*;

  gains_t            gains_r;
  logic [RAMP_W-1:0] ramp_limit_r;
  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic              tog_r, tog_nxt;
  logic [NSTG-1:0]   vld_r, vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NSTG:0]     rdy;
  logic [NSTG-1:0]   load;
  logic              out_load;
  logic              run_r [NSTG];
  logic [TGT_W-1:0]  tgt_r [NSTG];

  // configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kp   <= GAIN_PROP_RST;
      gains_r.ki   <= '0;
      gains_r.kd   <= '0;
      ramp_limit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:     gains_r.kp   <= cfg_data;
        CFG_GAIN_INTEGRAL: gains_r.ki   <= cfg_data;
        CFG_GAIN_DERIV:    gains_r.kd   <= cfg_data;
        CFG_RAMP_LIMIT:    ramp_limit_r <= cfg_data[RAMP_W-1:0];
        default: ;
      endcase
    end
  end
  assign gains = gains_r;

  // ready travels back from the output register; a stage takes an item when the next one frees
  always_comb begin
    rdy[NSTG] = !out_valid_r || out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    load[0] = in_valid && rdy[0];
    for (int k = 1; k < NSTG; k++) begin
      load[k] = vld_r[k-1] && rdy[k];
    end
    out_load = vld_r[NSTG-1] && rdy[NSTG];
    for (int k = 0; k < NSTG; k++) begin
      vld_nxt[k] = load[k] || (vld_r[k] && !rdy[k+1]);
    end
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  assign in_ready     = rdy[0];
  assign out_valid    = out_valid_r;
  assign ctl.load     = load;
  assign ctl.out_load = out_load;

  // ramp: target from the count before this tick's step, step on every second running tick
  assign target_now = TGT_W'({ramp_r, 2'b00}) + TGT_BASE;
  always_comb begin
    ramp_nxt = ramp_r;
    tog_nxt  = tog_r;
    if (load[0] && in_run) begin
      if (!tog_r && (ramp_r < ramp_limit_r)) begin
        ramp_nxt = ramp_r + 1'b1;
      end
      tog_nxt = !tog_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      ramp_r      <= '0;
      tog_r       <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      ramp_r      <= ramp_nxt;
      tog_r       <= tog_nxt;
    end
  end

  // carry run flag and target alongside the lanes
  always_ff @(posedge clk) begin
    if (load[0]) begin
      run_r[0] <= in_run;
      tgt_r[0] <= target_now;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (load[k]) begin
        run_r[k] <= run_r[k-1];
        tgt_r[k] <= tgt_r[k-1];
      end
    end
  end

  assign run_last    = run_r[NSTG-1];
  assign target_last = tgt_r[NSTG-1];

endmodule

// ----- rtl/dwp_lane.sv -----
// One wheel lane: error, integral and PID sum, then scaling to drive units.
module dwp_lane #(
  parameter int COUNT_BITS = 16,
  parameter int DRIVE_MAX  = 40000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dwp_pkg::stage_ctl_t               ctl,
  input  dwp_pkg::gains_t                   gains,
  input  logic                              run,
  input  logic [dwp_pkg::TGT_W-1:0]         target,
  input  logic [dwp_pkg::CNT_W-1:0]         count,
  output logic signed [dwp_pkg::O_W-1:0]    pid_out
);
  import dwp_pkg::*;

  localparam int CB = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
  localparam longint SAT_X = 4 * longint'(DRIVE_MAX) * 125;
  localparam int XW = $clog2(SAT_X);
  localparam int PW = XW + RECIP_W;
  localparam logic signed [DIFF_W-1:0] E_HI = DIFF_W'((2 ** (ERR_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] E_LO = DIFF_W'(-(2 ** (ERR_W - 1)));
  localparam logic signed [SUM_W:0] S_HI = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] S_LO = (SUM_W+1)'(-(64'sd1 <<< (SUM_W - 1)));

  // lane state
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ERR_W-1:0] last_r;

  // stage A .. F
  logic signed [ERR_W-1:0]          ea_r;
  logic signed [DIFF_W-1:0]         da_r;
  logic signed [SUM_W-1:0]          sa_r;
  logic signed [GAIN_W+ERR_W:0]     pb_r;
  logic signed [GAIN_W+SUM_W:0]     ib_r;
  logic signed [GAIN_W+DIFF_W:0]    db_r;
  logic signed [NUM_W-1:0]          pc_r, ic_r, dc_r;
  logic signed [NUM_W-1:0]          num_r;
  logic [XW-1:0]                    x_r;
  logic                             neg_e_r, sat_e_r;
  logic [PW-1:0]                    prod_r;
  logic                             neg_f_r, sat_f_r;

  logic [DIFF_W-1:0]        cnt_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] dlt;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [NUM_W-1:0]  pe, de;
  logic [NUM_W-1:0]         mag, xf;
  logic [O_W-1:0]           q, mag_o;

  // error, derivative and saturating integral
  always_comb begin
    cnt_ext = DIFF_W'(count[CB-1:0]);
    diff    = $signed(DIFF_W'(target) - cnt_ext * DIFF_W'(10));
    if (diff > E_HI) begin
      err = ERR_W'(E_HI);
    end else if (diff < E_LO) begin
      err = ERR_W'(E_LO);
    end else begin
      err = ERR_W'(diff);
    end
    dlt      = DIFF_W'(err) - DIFF_W'(last_r);
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err);
    if (sum_wide > S_HI) begin
      sum_sat = SUM_W'(S_HI);
    end else if (sum_wide < S_LO) begin
      sum_sat = SUM_W'(S_LO);
    end else begin
      sum_sat = SUM_W'(sum_wide);
    end
  end

  // hold state on a stopped tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else if (ctl.load[0] && run) begin
      sum_r  <= sum_sat;
      last_r <= err;
    end
  end

  // constant scaling by 50 and 2500 as shift-add
  always_comb begin
    pe  = NUM_W'(pb_r);
    de  = NUM_W'(db_r);
    mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    xf  = mag >> DIV_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      ea_r <= err;
      da_r <= dlt;
      sa_r <= sum_sat;
    end
    if (ctl.load[1]) begin
      pb_r <= $signed({1'b0, gains.kp}) * ea_r;
      ib_r <= $signed({1'b0, gains.ki}) * sa_r;
      db_r <= $signed({1'b0, gains.kd}) * da_r;
    end
    if (ctl.load[2]) begin
      pc_r <= (pe <<< 5) + (pe <<< 4) + (pe <<< 1);
      ic_r <= NUM_W'(ib_r);
      dc_r <= (de <<< 11) + (de <<< 8) + (de <<< 7) + (de <<< 6) + (de <<< 2);
    end
    if (ctl.load[3]) begin
      num_r <= pc_r + ic_r + dc_r;
    end
    if (ctl.load[4]) begin
      neg_e_r <= num_r[NUM_W-1];
      sat_e_r <= (xf >= NUM_W'(SAT_X));
      x_r     <= XW'(xf);
    end
    if (ctl.load[5]) begin
      neg_f_r <= neg_e_r;
      sat_f_r <= sat_e_r;
      prod_r  <= PW'(x_r) * PW'(RECIP_MUL);
    end
  end

  // quotient toward zero, limited to four times the drive range
  always_comb begin
    q       = O_W'(prod_r >> RECIP_SHIFT);
    mag_o   = sat_f_r ? O_W'(4 * DRIVE_MAX) : q;
    pid_out = neg_f_r ? $signed(-mag_o) : $signed(mag_o);
  end

endmodule

// ----- rtl/dwp_merge.sv -----
// Merge stage: both lanes' drive accumulators and the result register.
module dwp_merge #(
  parameter int DRIVE_MAX = 40000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_load,
  input  logic                              run,
  input  logic [dwp_pkg::TGT_W-1:0]         target,
  input  logic signed [dwp_pkg::O_W-1:0]    pid_left,
  input  logic signed [dwp_pkg::O_W-1:0]    pid_right,
  output logic signed [dwp_pkg::DRV_W-1:0]  left_drive,
  output logic signed [dwp_pkg::DRV_W-1:0]  right_drive,
  output logic [dwp_pkg::TGT_W-1:0]         target_tenths
);
  import dwp_pkg::*;

  localparam int ACC_W = O_W + 1;
  localparam logic signed [ACC_W-1:0] D_HI = ACC_W'(DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] D_LO = ACC_W'(-DRIVE_MAX);

  logic signed [DRV_W-1:0] acc_r [2];
  logic signed [DRV_W-1:0] acc_nxt [2];
  logic signed [O_W-1:0]   pid [2];
  logic signed [ACC_W-1:0] wide [2];
  logic [TGT_W-1:0]        tgt_r;

  assign pid[0] = pid_left;
  assign pid[1] = pid_right;

  // add each lane's output, clamp, zero on a stopped tick
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      wide[l] = ACC_W'(acc_r[l]) + ACC_W'(pid[l]);
      if (!run) begin
        acc_nxt[l] = '0;
      end else if (wide[l] > D_HI) begin
        acc_nxt[l] = DRV_W'(D_HI);
      end else if (wide[l] < D_LO) begin
        acc_nxt[l] = DRV_W'(D_LO);
      end else begin
        acc_nxt[l] = DRV_W'(wide[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end else if (out_load) begin
      acc_r[0] <= acc_nxt[0];
      acc_r[1] <= acc_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tgt_r <= target;
    end
  end

  assign left_drive    = acc_r[0];
  assign right_drive   = acc_r[1];
  assign target_tenths = tgt_r;

endmodule

// ----- rtl/dual_wheel_pid_speed_loop.sv -----
// Dual wheel incremental PID speed loop: top level.
//
// One input item per control tick carries run_enable and both wheels'
// encoder counts; each item yields one result item with both wheel drives
// and the ramped target in tenths of a count. Channels use valid/ready and
// an item moves at a clock edge where both are high. Gains and the ramp
// limit are written through the cfg channel, which is always ready; write
// them only while no item is in flight.
// The two wheel lanes each run a six stage pipeline (error and integral,
// gain multipliers, shift-add scaling, the PID sum, the magnitude shift and
// the reciprocal multiply for the divide by 128000) ahead of the merge
// register, so one item is taken every cycle while the receiver keeps up.
// Reset (rst_n low, synchronous) loads the default gains, clears ramp,
// integrals, previous errors and drive accumulators, and empties the pipe.
// When the receiver stalls, the result register holds its item and the
// stages behind it keep filling until all are occupied; only then does
// in_ready fall.
module dual_wheel_pid_speed_loop #(
  parameter int COUNT_BITS = 16,
  parameter int DRIVE_MAX  = 40000
) (
  input  logic          clk,
  input  logic          rst_n,
  dwp_in_if.sink        in_ch,
  dwp_out_if.source     out_ch,
  dwp_cfg_if.sink       cfg_ch
);
  import dwp_pkg::*;

  stage_ctl_t            ctl;
  gains_t                gains;
  logic [TGT_W-1:0]      target_now;
  logic                  run_last;
  logic [TGT_W-1:0]      target_last;
  logic signed [O_W-1:0] pid_left, pid_right;

  dwp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_run      (in_ch.run_enable),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .cfg_valid   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .cfg_ready   (cfg_ch.ready),
    .ctl         (ctl),
    .gains       (gains),
    .target_now  (target_now),
    .run_last    (run_last),
    .target_last (target_last)
  );

  dwp_lane #(.COUNT_BITS(COUNT_BITS), .DRIVE_MAX(DRIVE_MAX)) u_lane_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .gains   (gains),
    .run     (in_ch.run_enable),
    .target  (target_now),
    .count   (in_ch.left_count),
    .pid_out (pid_left)
  );

  dwp_lane #(.COUNT_BITS(COUNT_BITS), .DRIVE_MAX(DRIVE_MAX)) u_lane_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .gains   (gains),
    .run     (in_ch.run_enable),
    .target  (target_now),
    .count   (in_ch.right_count),
    .pid_out (pid_right)
  );

  dwp_merge #(.DRIVE_MAX(DRIVE_MAX)) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_load      (ctl.out_load),
    .run           (run_last),
    .target        (target_last),
    .pid_left      (pid_left),
    .pid_right     (pid_right),
    .left_drive    (out_ch.left_drive),
    .right_drive   (out_ch.right_drive),
    .target_tenths (out_ch.target_tenths)
  );

`ifndef SYNTHESIS
  // drives stay inside the saturation range
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.left_drive <= DRIVE_MAX) && (out_ch.left_drive >= -DRIVE_MAX)
                  && (out_ch.right_drive <= DRIVE_MAX) && (out_ch.right_drive >= -DRIVE_MAX))
    else $error("drive outside saturation range");

  // target is 4*ramp+70: at least 70 and two modulo four
  a_target_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.target_tenths >= TGT_BASE) && (out_ch.target_tenths[1:0] == 2'b10))
    else $error("target not of ramp form");

  // an empty result register means the whole pipe can take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // a stopped item leaves both drives at zero
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_load && !run_last) |=> (out_ch.left_drive == '0) && (out_ch.right_drive == '0))
    else $error("stopped item with nonzero drive");
`endif

endmodule
